/* rtl/tfn_pkg.sv */
package tfn_pkg;

	localparam int FRAC_BITS = 16;
	localparam int NORM_W = FRAC_BITS + 2;
	localparam int COORD_W = 32;
	localparam int EDGE_W = COORD_W + 1;
	localparam int PROD_W = 2 * EDGE_W;
	localparam int CROSS_W = PROD_W + 1;
	localparam int MAG_W = CROSS_W;
	localparam int QUO_W = FRAC_BITS + 2;
	localparam int DIV_STEPS = FRAC_BITS + 2;
	localparam int STEP_W = $clog2(DIV_STEPS + 1);
	localparam int QDEPTH = 2;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} vec_t;

	typedef struct packed {
		vec_t v0;
		vec_t v1;
		vec_t v2;
	} tri_t;

	typedef struct packed {
		logic signed [NORM_W-1:0] nx;
		logic signed [NORM_W-1:0] ny;
		logic signed [NORM_W-1:0] nz;
		logic                     degenerate;
	} norm_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EDGE,
		ST_MUL,
		ST_CROSS,
		ST_SEL,
		ST_DIV,
		ST_EMIT
	} back_state_t;

endpackage

/* rtl/tfn_front.sv */
module tfn_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          mode,
	input  logic          in_valid,
	output logic          in_ready,
	input  tfn_pkg::vec_t in_vec,
	output logic          tri_valid,
	input  logic          tri_ready,
	output tfn_pkg::tri_t tri_data
);
	import tfn_pkg::*;

	logic [1:0] count_q;
	vec_t       c0_q;
	vec_t       c1_q;
	logic       take;

	assign tri_valid = in_valid && mode && count_q[1];
	assign in_ready = !(mode && count_q[1]) || tri_ready;
	assign take = in_valid && in_ready;
	assign tri_data = '{v0: c0_q, v1: c1_q, v2: in_vec};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else if (take) begin
			if (!mode || count_q[1]) count_q <= 2'd0;
			else count_q <= count_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take && mode && count_q == 2'd0) c0_q <= in_vec;
		if (take && mode && count_q == 2'd1) c1_q <= in_vec;
	end

endmodule

/* rtl/tfn_queue.sv */
module tfn_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  tfn_pkg::tri_t wr_data,
	output logic          rd_valid,
	input  logic          rd_ready,
	output tfn_pkg::tri_t rd_data
);
	import tfn_pkg::*;

	tri_t       mem_q [QDEPTH];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;
	logic       wr_en;
	logic       rd_en;

	assign wr_ready = cnt_q != 2'(QDEPTH);
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data = mem_q[rptr_q];
	assign wr_en = wr_valid && wr_ready;
	assign rd_en = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) wptr_q <= !wptr_q;
			if (rd_en) rptr_q <= !rptr_q;
			cnt_q <= cnt_q + 2'(wr_en) - 2'(rd_en);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wptr_q] <= wr_data;
	end

endmodule

/* rtl/tfn_back.sv */
module tfn_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          tri_valid,
	output logic          tri_ready,
	input  tfn_pkg::tri_t tri_data,
	output logic          out_valid,
	input  logic          out_ready,
	output tfn_pkg::norm_t out_norm,
	output logic [1:0]    out_corner,
	output logic          out_last
);
	import tfn_pkg::*;

	back_state_t state_q, state_d;
	tri_t        tri_q;
	logic signed [EDGE_W-1:0]  a_q [3];
	logic signed [EDGE_W-1:0]  b_q [3];
	logic signed [PROD_W-1:0]  p_q [6];
	logic signed [CROSS_W-1:0] c_q [3];
	logic [MAG_W-1:0]          den_q;
	logic                      den_neg_q;
	logic [1:0]                comp_q;
	logic [STEP_W-1:0]         step_q;
	logic [MAG_W:0]            rem_q;
	logic [QUO_W-1:0]          quo_q;
	logic signed [NORM_W-1:0]  res_q [3];
	logic                      degen_q;
	logic [1:0]                corner_q;

	logic [MAG_W-1:0] mag [3];
	logic [1:0]       sel;
	logic [MAG_W:0]   rem_sh;
	logic [MAG_W:0]   rem_nx;
	logic             ge;
	logic [QUO_W-1:0] q_fin;
	logic [MAG_W-1:0] cur_mag;
	logic             div_done;
	logic             rem_ge;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = c_q[i][CROSS_W-1] ? MAG_W'(-c_q[i]) : MAG_W'(c_q[i]);
		end
		sel = (mag[0] > mag[1]) ? 2'd0 : 2'd1;
		if (mag[2] > mag[sel]) sel = 2'd2;
		cur_mag = mag[comp_q];
		rem_sh = (step_q == '0) ? {1'b0, cur_mag} : {rem_q[MAG_W-1:0], 1'b0};
		ge = rem_sh >= {1'b0, den_q};
		rem_nx = ge ? rem_sh - {1'b0, den_q} : rem_sh;
		rem_ge = {rem_q[MAG_W-1:0], 1'b0} >= {1'b0, den_q};
		q_fin = quo_q + QUO_W'(rem_ge);
		div_done = step_q == STEP_W'(DIV_STEPS - 1);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (tri_valid) state_d = ST_EDGE;
			ST_EDGE: state_d = ST_MUL;
			ST_MUL: state_d = ST_CROSS;
			ST_CROSS: state_d = ST_SEL;
			ST_SEL: state_d = ST_DIV;
			ST_DIV: if (degen_q || (div_done && comp_q == 2'd2)) state_d = ST_EMIT;
			ST_EMIT: if (out_ready && corner_q == 2'd2) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		tri_ready = state_q == ST_IDLE;
		out_valid = state_q == ST_EMIT;
		out_norm = '{nx: res_q[0], ny: res_q[1], nz: res_q[2], degenerate: degen_q};
		out_corner = corner_q;
		out_last = corner_q == 2'd2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			corner_q <= 2'd0;
			step_q <= '0;
			comp_q <= 2'd0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CROSS) begin
				step_q <= '0;
				comp_q <= 2'd0;
				corner_q <= 2'd0;
			end else if (state_q == ST_DIV && !degen_q) begin
				if (div_done) begin
					step_q <= '0;
					comp_q <= comp_q + 2'd1;
				end else begin
					step_q <= step_q + STEP_W'(1);
				end
			end
			if (state_q == ST_EMIT && out_ready) corner_q <= corner_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (tri_valid) tri_q <= tri_data;
			ST_EDGE: begin
				a_q[0] <= EDGE_W'(tri_q.v1.x) - EDGE_W'(tri_q.v0.x);
				a_q[1] <= EDGE_W'(tri_q.v1.y) - EDGE_W'(tri_q.v0.y);
				a_q[2] <= EDGE_W'(tri_q.v1.z) - EDGE_W'(tri_q.v0.z);
				b_q[0] <= EDGE_W'(tri_q.v2.x) - EDGE_W'(tri_q.v0.x);
				b_q[1] <= EDGE_W'(tri_q.v2.y) - EDGE_W'(tri_q.v0.y);
				b_q[2] <= EDGE_W'(tri_q.v2.z) - EDGE_W'(tri_q.v0.z);
			end
			ST_MUL: begin
				p_q[0] <= PROD_W'(a_q[1]) * PROD_W'(b_q[2]);
				p_q[1] <= PROD_W'(a_q[2]) * PROD_W'(b_q[1]);
				p_q[2] <= PROD_W'(a_q[2]) * PROD_W'(b_q[0]);
				p_q[3] <= PROD_W'(a_q[0]) * PROD_W'(b_q[2]);
				p_q[4] <= PROD_W'(a_q[0]) * PROD_W'(b_q[1]);
				p_q[5] <= PROD_W'(a_q[1]) * PROD_W'(b_q[0]);
			end
			ST_CROSS: begin
				for (int i = 0; i < 3; i++) begin
					c_q[i] <= CROSS_W'(p_q[2*i]) - CROSS_W'(p_q[2*i+1]);
				end
			end
			default: ;
		endcase
		if (state_q == ST_SEL) begin
			den_q <= mag[sel];
			den_neg_q <= c_q[sel][CROSS_W-1];
			degen_q <= mag[sel] == '0;
			if (mag[sel] == '0) begin
				for (int i = 0; i < 3; i++) res_q[i] <= '0;
			end
		end
		if (state_q == ST_DIV && !degen_q) begin
			rem_q <= rem_nx;
			if (div_done) begin
				res_q[comp_q] <= (c_q[comp_q][CROSS_W-1] != den_neg_q) ?
					NORM_W'(-q_fin) : NORM_W'(q_fin);
			end else begin
				quo_q <= (step_q == '0) ? QUO_W'(ge) : {quo_q[QUO_W-2:0], ge};
			end
		end
	end

endmodule

/* rtl/triangle_face_normal.sv */
// Channel      Direction  Payload
// s_axis       in         vertex position (pos_x, pos_y, pos_z)
// m_axis       out        face normal, corner, degenerate, tlast
// cfg          in         triangle_mode
// The last vertex of a triangle waits while the queue is full. The back end
// takes one triangle at a time; its shared bit-serial divider does three
// divisions of FRAC_BITS + 2 steps each, none when degenerate, before the
// three output transfers. A two-entry queue lets vertices arrive meanwhile.
// Reset sets triangle_mode and clears the corner count and queue.
module triangle_face_normal (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [95:0]  s_axis_tdata,  // pos_x, pos_y, pos_z
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [55:0]  m_axis_tdata,  // normal_x, normal_y, normal_z, corner
	output logic         m_axis_tuser,  // degenerate
	output logic         m_axis_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_data
);
	import tfn_pkg::*;

	logic  mode_q;
	vec_t  in_vec;
	logic  fq_valid, fq_ready, qb_valid, qb_ready;
	tri_t  fq_data, qb_data;
	norm_t norm;
	logic [1:0] corner;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mode_q <= 1'b1;
		else if (cfg_valid && cfg_ready) mode_q <= cfg_data;
	end

	assign in_vec = '{x: s_axis_tdata[31:0], y: s_axis_tdata[63:32], z: s_axis_tdata[95:64]};

	tfn_front u_front (
		.clk, .arst_n, .mode(mode_q),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_vec,
		.tri_valid(fq_valid), .tri_ready(fq_ready), .tri_data(fq_data)
	);

	tfn_queue u_queue (
		.clk, .arst_n,
		.wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
		.rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_data)
	);

	tfn_back u_back (
		.clk, .arst_n,
		.tri_valid(qb_valid), .tri_ready(qb_ready), .tri_data(qb_data),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_norm(norm), .out_corner(corner), .out_last(m_axis_tlast)
	);

	assign m_axis_tdata = {corner, norm.nz, norm.ny, norm.nx};
	assign m_axis_tuser = norm.degenerate;

endmodule

/* rtl/tfn_checker.sv */
module tfn_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [55:0] m_axis_tdata,
	input logic        m_axis_tuser,
	input logic        m_axis_tlast
);
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output changed while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tlast == (m_axis_tdata[55:54] == 2'd2))
		else $error("tlast mismatch with corner");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[53:0] == '0)
		else $error("degenerate normal not zero");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[55:54] != 2'd3)
		else $error("corner out of range");
endmodule

bind triangle_face_normal tfn_checker u_checker (
	.clk, .arst_n, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
);
